/* design/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RAR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define RAR_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RAR_ASSERT(label, clk, rst_n, prop)
`define RAR_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* design/rar_pkg.sv */
`default_nettype none
package rar_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned MagW     = 64;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         status;
  } out_req_t;

  // Unreduced fraction in sign/magnitude form.
  typedef struct packed {
    logic            n_neg;
    logic [MagW-1:0] n_mag;
    logic            d_neg;
    logic [MagW-1:0] d_mag;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* design/rar_front.sv */
`default_nettype none
module rar_front #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rar_pkg::in_req_t req_i,
  output logic                 full_o,
  input  wire rar_pkg::q_stat_t q_stat_i,
  output logic                 q_push_o,
  output rar_pkg::work_t       q_data_o
);
  import rar_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_P0, F_P1, F_P2, F_SUM} fstate_e;

  localparam logic [31:0] WMask = 32'((64'd1 << WIDTH) - 64'd1);

  fstate_e state_q, state_d;

  logic [1:0]  mode_q;
  logic        an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic [31:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
  logic        p0_neg_q, p1_neg_q, pd_neg_q;
  logic [MagW-1:0] p0_mag_q, p1_mag_q, pd_mag_q;

  logic [31:0]     mul_a, mul_b;
  logic            sgn_a, sgn_b;
  logic [MagW-1:0] prod;
  logic            prod_neg;
  logic            accept;

  function automatic logic [32:0] decode(input logic [31:0] raw);
    logic [31:0] x;
    logic        neg;
    x   = raw & WMask;
    neg = x[WIDTH-1];
    return {neg, neg ? ((~x + 32'd1) & WMask) : x};
  endfunction

  assign accept = push_i && !full_o;
  assign full_o = (state_q != F_IDLE);

  // one shared multiplier, operands picked by step
  always_comb begin
    mul_a = an_mag_q; mul_b = bd_mag_q; sgn_a = an_neg_q; sgn_b = bd_neg_q;
    case (state_q)
      F_P0: begin
        if (mode_q == MODE_MUL) begin
          mul_b = bn_mag_q; sgn_b = bn_neg_q;
        end
      end
      F_P1: begin
        mul_a = bn_mag_q; sgn_a = bn_neg_q; mul_b = ad_mag_q; sgn_b = ad_neg_q;
      end
      F_P2: begin
        mul_a = ad_mag_q; sgn_a = ad_neg_q;
        if (mode_q == MODE_DIV) begin
          mul_b = bn_mag_q; sgn_b = bn_neg_q;
        end
      end
      default: ;
    endcase
    prod     = {32'd0, mul_a} * {32'd0, mul_b};
    prod_neg = (prod != '0) && (sgn_a ^ sgn_b);
  end

  // numerator combine (add/sub) in sign/magnitude
  always_comb begin
    q_data_o.d_neg = pd_neg_q;
    q_data_o.d_mag = pd_mag_q;
    q_data_o.n_neg = p0_neg_q;
    q_data_o.n_mag = p0_mag_q;
    if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
      if (p0_neg_q == p1_neg_q) begin
        q_data_o.n_mag = p0_mag_q + p1_mag_q;
      end else if (p0_mag_q >= p1_mag_q) begin
        q_data_o.n_mag = p0_mag_q - p1_mag_q;
      end else begin
        q_data_o.n_mag = p1_mag_q - p0_mag_q;
        q_data_o.n_neg = p1_neg_q;
      end
      if (q_data_o.n_mag == '0) begin
        q_data_o.n_neg = 1'b0;
      end
    end
  end

  assign q_push_o = (state_q == F_SUM) && !q_stat_i.full;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_P0;
      F_P0: begin
        state_d = (mode_q == MODE_ADD || mode_q == MODE_SUB) ? F_P1 : F_P2;
      end
      F_P1: state_d = F_P2;
      F_P2: state_d = F_SUM;
      F_SUM: if (q_push_o) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q               <= req_i.mode;
      {an_neg_q, an_mag_q} <= decode(req_i.a_num);
      {ad_neg_q, ad_mag_q} <= decode(req_i.a_den);
      {bn_neg_q, bn_mag_q} <= decode(req_i.b_num);
      {bd_neg_q, bd_mag_q} <= decode(req_i.b_den);
    end
    case (state_q)
      F_P0: begin
        p0_mag_q <= prod; p0_neg_q <= prod_neg;
      end
      F_P1: begin
        p1_mag_q <= prod;
        p1_neg_q <= (mode_q == MODE_SUB) ? ((prod != '0) && !prod_neg) : prod_neg;
      end
      F_P2: begin
        pd_mag_q <= prod; pd_neg_q <= prod_neg;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* design/rar_queue.sv */
`default_nettype none
`include "assert_macros.svh"
module rar_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rar_pkg::work_t   data_i,
  input  wire logic             pop_i,
  output rar_pkg::work_t        data_o,
  output rar_pkg::q_stat_t      stat_o
);
  import rar_pkg::*;

  work_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  `RAR_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  `RAR_NEVER(a_push_full, clk_i, rst_ni, push_i && stat_o.full)
  `RAR_ASSERT(a_ptr_cnt, clk_i, rst_ni, (cnt_q == 2'd1) == (wr_q != rd_q))

endmodule
`default_nettype wire

/* design/rar_back.sv */
`default_nettype none
`include "assert_macros.svh"
module rar_back #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rar_pkg::q_stat_t q_stat_i,
  input  wire rar_pkg::work_t   q_data_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output rar_pkg::out_req_t     rsp_o
);
  import rar_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIV, B_DONE} bstate_e;

  localparam logic [31:0]     WMask = 32'((64'd1 << WIDTH) - 64'd1);
  localparam logic [MagW-1:0] Half  = 64'd1 << (WIDTH - 1);

  bstate_e state_q, state_d;
  logic    res_valid_q;
  out_req_t res_q;

  logic            n_neg_q, d_neg_q, zden_q;
  logic [MagW-1:0] u_q, v_q, g_q, xn_q, xd_q, qn_q, qd_q;
  logic [MagW:0]   rn_q, rd_q;
  logic [6:0]      k_q;
  logic [5:0]      cnt_q;

  logic [MagW:0]   rn_sh, rd_sh;
  logic            rn_ge, rd_ge;
  logic            res_free;
  out_req_t        fin;

  assign res_free = !res_valid_q || pop_i;
  assign q_pop_o  = (state_q == B_IDLE) && !q_stat_i.empty;
  assign empty_o  = !res_valid_q;
  assign rsp_o    = res_q;

  // restoring divide step, numerator and denominator side by side
  assign rn_sh = {rn_q[MagW-1:0], xn_q[MagW-1]};
  assign rd_sh = {rd_q[MagW-1:0], xd_q[MagW-1]};
  assign rn_ge = rn_sh >= {1'b0, g_q};
  assign rd_ge = rd_sh >= {1'b0, g_q};

  function automatic logic [31:0] encode(input logic neg, input logic [MagW-1:0] mag);
    logic [MagW-1:0] w;
    logic [31:0]     lw;
    w  = neg ? (~mag + 64'd1) : mag;
    lw = w[31:0] & WMask;
    if (lw[WIDTH-1]) lw = lw | ~WMask;
    return lw;
  endfunction

  function automatic logic fits(input logic neg, input logic [MagW-1:0] mag);
    return neg ? (mag <= Half) : (mag < Half);
  endfunction

  always_comb begin
    fin.res_num = encode(n_neg_q, qn_q);
    fin.res_den = encode(d_neg_q, qd_q);
    fin.status  = (fits(n_neg_q, qn_q) && fits(d_neg_q, qd_q)) ? STATUS_OK
                                                                : STATUS_OVERFLOW;
    if (zden_q) begin
      fin.res_num = '0;
      fin.res_den = '0;
      fin.status  = STATUS_ZERO_DEN;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_pop_o) state_d = (q_data_i.d_mag == '0) ? B_DONE : B_GCD;
      end
      B_GCD:  if (u_q == '0) state_d = B_DIV;
      B_DIV:  if (cnt_q == 6'd63) state_d = B_DONE;
      B_DONE: if (res_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DONE && res_free) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (q_pop_o) begin
          n_neg_q <= q_data_i.n_neg;
          d_neg_q <= q_data_i.d_neg;
          zden_q  <= (q_data_i.d_mag == '0);
          u_q     <= q_data_i.n_mag;
          v_q     <= q_data_i.d_mag;
          xn_q    <= q_data_i.n_mag;
          xd_q    <= q_data_i.d_mag;
          k_q     <= '0;
        end
      end
      B_GCD: begin
        // binary gcd, one step a cycle
        if (u_q == '0) begin
          g_q   <= v_q << k_q[5:0];
          rn_q  <= '0;
          rd_q  <= '0;
          cnt_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1; v_q <= v_q >> 1; k_q <= k_q + 7'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      B_DIV: begin
        rn_q  <= rn_ge ? (rn_sh - {1'b0, g_q}) : rn_sh;
        rd_q  <= rd_ge ? (rd_sh - {1'b0, g_q}) : rd_sh;
        qn_q  <= {qn_q[MagW-2:0], rn_ge};
        qd_q  <= {qd_q[MagW-2:0], rd_ge};
        xn_q  <= xn_q << 1;
        xd_q  <= xd_q << 1;
        cnt_q <= cnt_q + 6'd1;
      end
      B_DONE: begin
        if (res_free) res_q <= fin;
      end
      default: ;
    endcase
  end

  `RAR_NEVER(a_gcd_v_zero, clk_i, rst_ni, state_q == B_GCD && v_q == '0)
  `RAR_NEVER(a_k_range, clk_i, rst_ni, state_q == B_GCD && k_q > 7'd63)
  `RAR_ASSERT(a_zden_out, clk_i, rst_ni,
    (res_valid_q && res_q.status == STATUS_ZERO_DEN) |-> (res_q.res_num == '0))

endmodule
`default_nettype wire

/* design/rational_arith_reduce_core.sv */
// Rational add/sub/mul/div of two fractions with gcd reduction.
// Flow: front steps P0, P1, P2 and SUM (P1 skipped for mul/div; one shared 32x32
// multiplier), then a pop, binary gcd steps, 64 divide steps and a result register.
// Throughput: the front takes a new request only once the last is in the queue;
// the back's gcd loop sets the pace, or the front's with a zero denominator.
// Reset: rst_ni asynchronous, active low; clears all control, queue empty.
`default_nettype none
module rational_arith_reduce_core #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request side
  input  wire logic              push,
  output logic                   full,
  input  wire rar_pkg::in_req_t  req_i,
  // result side
  output logic                   empty,
  input  wire logic              pop,
  output rar_pkg::out_req_t      rsp_o
);
  import rar_pkg::*;

  // front -> queue -> back
  q_stat_t q_stat;
  work_t   f_data, b_data;
  logic    f_push, b_pop;

  // Front: takes a request, forms the cross products and, for add/sub, sums them.
  rar_front #(.WIDTH(WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (req_i),
    .full_o   (full),
    .q_stat_i (q_stat),
    .q_push_o (f_push),
    .q_data_o (f_data)
  );

  // Two-deep queue of unreduced fractions, decouples the two halves.
  rar_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i (f_data),
    .pop_i  (b_pop),
    .data_o (b_data),
    .stat_o (q_stat)
  );

  // Back: gcd, divides both parts by it, packs status; holds one result.
  rar_back #(.WIDTH(WIDTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_data_i (b_data),
    .q_pop_o  (b_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .rsp_o    (rsp_o)
  );

endmodule
`default_nettype wire
